FILE: rtl/hpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap priority queue package
// Sizes, request and response types, and the command and response records
// that pass between the controller and the row of level cells.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned LEVELS   = $clog2(CAPACITY + 1);
  localparam int unsigned LVL_W    = $clog2(LEVELS);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = LEVELS - 1;
  localparam int unsigned ROW_W    = (LEVELS > 2) ? LEVELS - 2 : 1;
  localparam int unsigned EXT_W    = CNT_W + 1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_UPDATE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] key_id;
    logic [15:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [15:0] out_id;
    logic [15:0] out_priority;
    status_e     status;
    logic [7:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [LVL_W-1:0] lvl;
    logic [ROW_W-1:0] row;
    logic             wr_odd;
    entry_t           wdata;
    logic [15:0]      key;
  } cell_cmd_t;

  typedef struct packed {
    entry_t even;
    entry_t odd;
    logic   hit_even;
    logic   hit_odd;
    logic   odd_gt;
  } cell_rsp_t;

  // Rows of sibling pairs held by one level of the heap.
  function automatic int unsigned lvl_rows(input int unsigned lvl);
    int unsigned first;
    int unsigned ents;
    first = (1 << lvl) - 1;
    ents  = ((CAPACITY - first) < (1 << lvl)) ? (CAPACITY - first) : (1 << lvl);
    return (ents + 1) >> 1;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hpq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Single-port RAM
// One access per cycle, write or registered read.
// ----------------------------------------------------------------------------
module hpq_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap level cell
// Decodes the controller command for one heap level, drives the even and odd
// sibling memories of that level and compares the pair that was read.
// ----------------------------------------------------------------------------
module hpq_cell (
  input  logic [hpq_pkg::LVL_W-1:0] lvl_i,
  input  hpq_pkg::cell_cmd_t        cmd_i,
  input  hpq_pkg::entry_t           even_rd_i,
  input  hpq_pkg::entry_t           odd_rd_i,
  output logic                      even_we_o,
  output logic                      odd_we_o,
  output logic                      re_o,
  output logic [hpq_pkg::ROW_W-1:0] addr_o,
  output hpq_pkg::entry_t           wdata_o,
  output hpq_pkg::cell_rsp_t        rsp_o
);
  import hpq_pkg::*;

  logic sel;

  assign sel       = (cmd_i.lvl == lvl_i);
  assign even_we_o = sel && cmd_i.wr_en && !cmd_i.wr_odd;
  assign odd_we_o  = sel && cmd_i.wr_en && cmd_i.wr_odd;
  assign re_o      = sel && cmd_i.rd_en;
  assign addr_o    = cmd_i.row;
  assign wdata_o   = cmd_i.wdata;

  assign rsp_o.even     = even_rd_i;
  assign rsp_o.odd      = odd_rd_i;
  assign rsp_o.hit_even = (even_rd_i.id == cmd_i.key);
  assign rsp_o.hit_odd  = (odd_rd_i.id == cmd_i.key);
  assign rsp_o.odd_gt   = (odd_rd_i.prio > even_rd_i.prio);

endmodule
`default_nettype wire

FILE: rtl/hpq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap priority queue controller
// Sequences search, sift-up and sift-down over the level cells and holds the
// request, the moving entry and the response register.
// ----------------------------------------------------------------------------
module hpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hpq_pkg::req_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hpq_pkg::rsp_t       out_data_o,
  output hpq_pkg::cell_cmd_t  cmd_o,
  input  hpq_pkg::cell_rsp_t  cell_rsp_i [hpq_pkg::LEVELS]
);
  import hpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_GOT_RD, S_GOT_CHK, S_LAST_RD, S_LAST_CHK,
    S_UP_RD, S_UP_CHK, S_DN_RD, S_DN_CHK, S_POST, S_RESP
  } state_e;

  // Level of an index, given the index plus one.
  function automatic logic [LVL_W-1:0] lvl_of(input logic [CNT_W-1:0] num);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (num[b]) l = LVL_W'(b);
    end
    return l;
  endfunction

  function automatic logic [POS_W-1:0] pos_of(input logic [IDX_W-1:0] idx,
                                              input logic [LVL_W-1:0] lvl);
    logic [CNT_W-1:0] num;
    num = CNT_W'(idx) + CNT_W'(1);
    return POS_W'(num - (CNT_W'(1) << lvl));
  endfunction

  state_e           state_q, state_d;
  action_e          act_q, act_d;
  logic [15:0]      key_q, key_d, pri_q, pri_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [LVL_W-1:0] lvl_q, lvl_d, rd_lvl_q, rd_lvl_d;
  entry_t           item_q, item_d, got_q, got_d;
  logic             ins_q, ins_d;
  rsp_t             res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;

  cell_rsp_t        rsp_sel;
  logic [POS_W-1:0] pos, par_pos, last_pos;
  logic [LVL_W-1:0] last_lvl;
  logic [EXT_W-1:0] idx_ext, n_ext, kid, scan_nxt;
  entry_t           par, kid_ent, tgot;
  logic             take, rgt;
  logic [IDX_W-1:0] tpos;
  logic [CNT_W-1:0] newn;

  assign rsp_sel  = cell_rsp_i[rd_lvl_q];
  assign pos      = pos_of(idx_q, lvl_q);
  assign par_pos  = pos >> 1;
  assign last_lvl = lvl_of(cnt_q + CNT_W'(1));
  assign last_pos = pos_of(IDX_W'(cnt_q), last_lvl);
  assign idx_ext  = EXT_W'(idx_q);
  assign n_ext    = EXT_W'(cnt_q);
  assign kid      = (idx_ext << 1) + EXT_W'(1);
  assign scan_nxt = idx_ext + ((lvl_q == '0) ? EXT_W'(1) : EXT_W'(2));
  assign par      = par_pos[0] ? rsp_sel.odd : rsp_sel.even;
  assign rgt      = ((kid + EXT_W'(1)) < n_ext) && rsp_sel.odd_gt;
  assign kid_ent  = rgt ? rsp_sel.odd : rsp_sel.even;
  assign newn     = cnt_q - CNT_W'(1);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    pri_d       = pri_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    lvl_d       = lvl_q;
    rd_lvl_d    = rd_lvl_q;
    item_d      = item_q;
    got_d       = got_q;
    ins_d       = ins_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    take        = 1'b0;
    tpos        = idx_q;
    tgot        = rsp_sel.even;

    cmd_o.rd_en  = 1'b0;
    cmd_o.wr_en  = 1'b0;
    cmd_o.lvl    = lvl_q;
    cmd_o.row    = ROW_W'(pos >> 1);
    cmd_o.wr_odd = pos[0];
    cmd_o.wdata  = item_q;
    cmd_o.key    = key_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d  = in_data_i.action;
          key_d  = in_data_i.key_id;
          pri_d  = in_data_i.priority_req;
          item_d = {in_data_i.key_id, in_data_i.priority_req};
          ins_d  = 1'b0;
          if (in_data_i.action == ACT_INSERT) begin
            if (cnt_q >= CNT_W'(CAPACITY)) begin
              res_d.out_id       = in_data_i.key_id;
              res_d.out_priority = in_data_i.priority_req;
              res_d.status       = ST_FULL;
              res_d.occupancy    = 8'(cnt_q);
              state_d            = S_RESP;
            end else begin
              idx_d   = IDX_W'(cnt_q);
              lvl_d   = lvl_of(cnt_q + CNT_W'(1));
              cnt_d   = cnt_q + CNT_W'(1);
              ins_d   = 1'b1;
              state_d = S_UP_RD;
            end
          end else if (cnt_q == '0) begin
            res_d.out_id       = '0;
            res_d.out_priority = '0;
            res_d.status       = ST_EMPTY;
            res_d.occupancy    = 8'(cnt_q);
            state_d            = S_RESP;
          end else begin
            idx_d   = '0;
            lvl_d   = '0;
            state_d = (in_data_i.action == ACT_POP) ? S_GOT_RD : S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_lvl_d    = lvl_q;
        state_d     = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if ((idx_ext < n_ext) && rsp_sel.hit_even) begin
          take = 1'b1;
        end else if ((lvl_q != '0) && ((idx_ext + EXT_W'(1)) < n_ext) && rsp_sel.hit_odd) begin
          take = 1'b1;
          tpos = idx_q + IDX_W'(1);
          tgot = rsp_sel.odd;
        end else if (scan_nxt >= n_ext) begin
          res_d.out_id       = key_q;
          res_d.out_priority = '0;
          res_d.status       = ST_MISSING;
          res_d.occupancy    = 8'(cnt_q);
          state_d            = S_RESP;
        end else begin
          idx_d = IDX_W'(scan_nxt);
          if ((scan_nxt + EXT_W'(1)) == (EXT_W'(1) << (EXT_W'(lvl_q) + EXT_W'(1)))) begin
            lvl_d = lvl_q + LVL_W'(1);
          end
          state_d = S_SCAN_RD;
        end
      end
      S_GOT_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_lvl_d    = '0;
        state_d     = S_GOT_CHK;
      end
      S_GOT_CHK: begin
        take = 1'b1;
      end
      S_LAST_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.lvl   = last_lvl;
        cmd_o.row   = ROW_W'(last_pos >> 1);
        rd_lvl_d    = last_lvl;
        state_d     = S_LAST_CHK;
      end
      S_LAST_CHK: begin
        item_d  = last_pos[0] ? rsp_sel.odd : rsp_sel.even;
        state_d = S_UP_RD;
      end
      S_UP_RD: begin
        if (idx_q == '0) begin
          if (ins_q) begin
            cmd_o.wr_en        = 1'b1;
            res_d.out_id       = key_q;
            res_d.out_priority = (act_q == ACT_INSERT) ? pri_q : got_q.prio;
            res_d.status       = ST_OK;
            res_d.occupancy    = 8'(cnt_q);
            state_d            = S_RESP;
          end else begin
            state_d = S_DN_RD;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.lvl   = lvl_q - LVL_W'(1);
          cmd_o.row   = ROW_W'(par_pos >> 1);
          rd_lvl_d    = lvl_q - LVL_W'(1);
          state_d     = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (par.prio >= item_q.prio) begin
          if (ins_q) begin
            cmd_o.wr_en        = 1'b1;
            res_d.out_id       = key_q;
            res_d.out_priority = (act_q == ACT_INSERT) ? pri_q : got_q.prio;
            res_d.status       = ST_OK;
            res_d.occupancy    = 8'(cnt_q);
            state_d            = S_RESP;
          end else begin
            state_d = S_DN_RD;
          end
        end else begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wdata = par;
          idx_d       = (idx_q - IDX_W'(1)) >> 1;
          lvl_d       = lvl_q - LVL_W'(1);
          state_d     = S_UP_RD;
        end
      end
      S_DN_RD: begin
        if (kid >= n_ext) begin
          cmd_o.wr_en = 1'b1;
          state_d     = S_POST;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.lvl   = lvl_q + LVL_W'(1);
          cmd_o.row   = ROW_W'(pos);
          rd_lvl_d    = lvl_q + LVL_W'(1);
          state_d     = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        cmd_o.wr_en = 1'b1;
        if (item_q.prio >= kid_ent.prio) begin
          state_d = S_POST;
        end else begin
          cmd_o.wdata = kid_ent;
          idx_d       = IDX_W'(kid + EXT_W'(rgt));
          lvl_d       = lvl_q + LVL_W'(1);
          state_d     = S_DN_RD;
        end
      end
      S_POST: begin
        if (act_q == ACT_UPDATE) begin
          idx_d   = IDX_W'(cnt_q);
          lvl_d   = last_lvl;
          cnt_d   = cnt_q + CNT_W'(1);
          ins_d   = 1'b1;
          item_d  = {key_q, pri_q};
          state_d = S_UP_RD;
        end else begin
          res_d.out_id       = (act_q == ACT_POP) ? got_q.id : key_q;
          res_d.out_priority = got_q.prio;
          res_d.status       = ST_OK;
          res_d.occupancy    = 8'(cnt_q);
          state_d            = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (take) begin
      got_d   = tgot;
      idx_d   = tpos;
      cnt_d   = newn;
      state_d = (CNT_W'(tpos) < newn) ? S_LAST_RD : S_POST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    key_q    <= key_d;
    pri_q    <= pri_d;
    idx_q    <= idx_d;
    lvl_q    <= lvl_d;
    rd_lvl_q <= rd_lvl_d;
    item_q   <= item_d;
    got_q    <= got_d;
    ins_q    <= ins_d;
    res_q    <= res_d;
  end

endmodule
`default_nettype wire

FILE: rtl/binary_max_heap_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Binary max-heap priority queue
// Insert, pop-max, remove-by-id and update of (id, priority) entries.
// ----------------------------------------------------------------------------
// The heap is kept as a row of level cells, one per tree level, each with a
// pair of single-port memories for even and odd siblings, so every step of
// the controller is one memory access, a read then a check. An insert climbs
// the entry level by level; a pop takes the root and sinks the last entry
// level by level; a remove or update first scans the heap in array order,
// one sibling pair per read, then repairs it the same way. One request is in
// work at a time; a finished response waits in the output register while
// the next request is taken.
module binary_max_heap_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hpq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hpq_pkg::rsp_t out_data_o
);
  import hpq_pkg::*;

  cell_cmd_t cmd;
  cell_rsp_t cell_rsp [LEVELS];

  hpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .cell_rsp_i  (cell_rsp)
  );

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    localparam int unsigned ROWS = lvl_rows(g);
    localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic             even_we;
    logic             odd_we;
    logic             re;
    logic [ROW_W-1:0] addr;
    entry_t           wdata;
    entry_t           even_rd;
    entry_t           odd_rd;

    hpq_cell u_cell (
      .lvl_i     (LVL_W'(g)),
      .cmd_i     (cmd),
      .even_rd_i (even_rd),
      .odd_rd_i  (odd_rd),
      .even_we_o (even_we),
      .odd_we_o  (odd_we),
      .re_o      (re),
      .addr_o    (addr),
      .wdata_o   (wdata),
      .rsp_o     (cell_rsp[g])
    );

    hpq_ram #(
      .DEPTH (ROWS),
      .WIDTH ($bits(entry_t))
    ) u_ram_even (
      .clk_i   (clk_i),
      .we_i    (even_we),
      .re_i    (re),
      .addr_i  (addr[AW-1:0]),
      .wdata_i (wdata),
      .rdata_o (even_rd)
    );

    hpq_ram #(
      .DEPTH (ROWS),
      .WIDTH ($bits(entry_t))
    ) u_ram_odd (
      .clk_i   (clk_i),
      .we_i    (odd_we),
      .re_i    (re),
      .addr_i  (addr[AW-1:0]),
      .wdata_i (wdata),
      .rdata_o (odd_rd)
    );
  end

endmodule
`default_nettype wire
